### rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bus mapper
// Operation codes, register indexes, decode kinds and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

    // Operation codes carried in the input transaction
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAP_MODE = 2'd0;
    localparam logic [1:0] CFG_ROM_SIZE = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE = 2'd2;
    localparam logic [1:0] CFG_FAST_ROM = 2'd3;

    // Field and register widths
    localparam int ADDR_W     = 24;
    localparam int DATA_W     = 8;
    localparam int ROM_SIZE_W = 23;
    localparam int RAM_SIZE_W = 18;
    localparam int CFG_W      = 23;

    // Remainder unit: decoded indexes never exceed 22 bits
    localparam int IDX_W     = 22;
    localparam int DIV_STEPS = IDX_W;
    localparam int DIV_CNT_W = 5;

    // Bus decode constants
    localparam logic [7:0] BANK_WRAM0   = 8'h7E;
    localparam logic [7:0] BANK_WRAM1   = 8'h7F;
    localparam logic [7:0] BANK_SRAM_LO = 8'h70;
    localparam logic [7:0] BANK_SRAM_HI = 8'h7D;
    localparam logic [7:0] BANK_HI_ROM  = 8'hC0;
    localparam logic [7:0] BANK_MID_LO  = 8'h40;
    localparam logic [7:0] BANK_HSRAM_LO = 8'h30;
    localparam logic [7:0] BANK_HSRAM_HI = 8'h3F;
    localparam logic [15:0] OFF_HSRAM_LO = 16'h6000;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ROM,
        KIND_RAM
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ACCESS,
        ST_RESP
    } state_t;

endpackage : cbm_pkg

`default_nettype wire

### rtl/cartridge_bus_mapper_core.sv
// ----------------------------------------------------------------------------
// cartridge_bus_mapper_core: LoROM / HiROM cartridge bus mapper
// Decodes 24-bit bus accesses into cartridge ROM or save RAM, and loads ROM.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one access per transaction (read, write or ROM load);
//   m_* stream returns exactly one result per access, in order.
//   cfg_we/cfg_addr/cfg_wdata write the mapping registers while idle.
// Access sequence:
//   An accepted access moves to ST_ACCESS, where the memory is read or
//   written and the read data registered, then to ST_RESP, where the
//   result register is loaded. An index at or above the effective ROM size
//   (HiROM reads) or RAM size is first reduced by a bit-serial remainder unit.
//   A new access is taken in the cycle its predecessor's result is loaded,
//   and not before.
// Reset:
//   Registers return to their reset values, then a clearing pass writes zero
//   to every save RAM entry, one per cycle; s_tready stays low during the
//   pass. ROM contents are undefined until loaded.
// Stall:
//   The result register holds while m_tready is low; one further access may
//   be accepted and decoded, and waits with its result until the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bus_mapper_core
    import cbm_pkg::*;
#(
    parameter int ROM_DEPTH = 1048576,
    parameter int RAM_DEPTH = 8192
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration write port
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    // Access stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // operation[1:0], address[25:2], write_data[33:26]
    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata    // read_data[7:0], rom_hit[8], ram_hit[9], speed_flag[10]
);

    localparam int ROM_AW = $clog2(ROM_DEPTH);
    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam logic [ROM_SIZE_W-1:0] ROM_LIMIT = ROM_SIZE_W'(ROM_DEPTH);
    localparam logic [RAM_SIZE_W-1:0] RAM_LIMIT = RAM_SIZE_W'(RAM_DEPTH);
    localparam logic [ADDR_W-1:0]     LOAD_LIMIT = ADDR_W'(ROM_DEPTH);
    localparam logic [RAM_AW-1:0]     CLR_LAST  = RAM_AW'(RAM_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  map_mode_reg;
    logic [ROM_SIZE_W-1:0] rom_size_reg;
    logic [RAM_SIZE_W-1:0] ram_size_reg;
    logic                  fast_rom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg <= 1'b0;
            rom_size_reg <= ROM_SIZE_W'(1048576);
            ram_size_reg <= RAM_SIZE_W'(8192);
            fast_rom_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAP_MODE: map_mode_reg <= cfg_wdata[0];
                CFG_ROM_SIZE: rom_size_reg <= cfg_wdata[ROM_SIZE_W-1:0];
                CFG_RAM_SIZE: ram_size_reg <= cfg_wdata[RAM_SIZE_W-1:0];
                CFG_FAST_ROM: fast_rom_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp sizes to the physical store depths
    logic [ROM_SIZE_W-1:0] eff_rom;
    logic [RAM_SIZE_W-1:0] eff_ram;

    assign eff_rom = (rom_size_reg > ROM_LIMIT) ? ROM_LIMIT : rom_size_reg;
    assign eff_ram = (ram_size_reg > RAM_LIMIT) ? RAM_LIMIT : ram_size_reg;

    // ------------------------------------------------------------------
    // Address decode of the incoming transaction
    // ------------------------------------------------------------------
    logic [1:0]        in_op;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_wdata;
    logic [7:0]        bank;
    logic [15:0]       off;

    assign in_op    = s_tdata[1:0];
    assign in_addr  = s_tdata[25:2];
    assign in_wdata = s_tdata[33:26];
    assign bank     = in_addr[23:16];
    assign off      = in_addr[15:0];

    kind_t                 dec_kind;
    logic [IDX_W-1:0]      dec_idx;
    logic [ROM_SIZE_W-1:0] dec_div;
    logic                  dec_need_div;
    logic                  dec_load;
    logic [IDX_W-1:0]      lo_rom_idx;

    assign lo_rom_idx = {bank[6:0], off[14:0]};

    always_comb
    begin
        dec_kind = KIND_NONE;
        dec_idx  = in_addr[IDX_W-1:0];
        dec_div  = '0;
        dec_load = (in_op == OP_LOAD) && (in_addr < LOAD_LIMIT);
        if ((in_op == OP_READ) || (in_op == OP_WRITE))
        begin
            if (!map_mode_reg)
            begin
                // LoROM: ROM in the upper half of each bank but 7E/7F, bounded not wrapped
                if (off[15] && (bank != BANK_WRAM0) && (bank != BANK_WRAM1))
                begin
                    dec_idx = lo_rom_idx;
                    if (({1'b0, lo_rom_idx} < eff_rom) && (in_op == OP_READ))
                    begin
                        dec_kind = KIND_ROM;
                        dec_div  = eff_rom;
                    end
                end
                else if ((bank >= BANK_SRAM_LO) && (bank <= BANK_SRAM_HI) && !off[15])
                begin
                    dec_kind = KIND_RAM;
                    dec_idx  = IDX_W'({bank[3:0], off[14:0]});
                    dec_div  = ROM_SIZE_W'(eff_ram);
                end
            end
            else
            begin
                // HiROM: every ROM window reduces to bank[5:0] and offset
                if ((bank >= BANK_HI_ROM) || ((bank >= BANK_MID_LO) && (bank <= BANK_SRAM_HI))
                    || (!bank[6] && off[15]))
                begin
                    dec_idx = {bank[5:0], off};
                    if ((eff_rom != '0) && (in_op == OP_READ))
                    begin
                        dec_kind = KIND_ROM;
                        dec_div  = eff_rom;
                    end
                end
                else if ((bank >= BANK_HSRAM_LO) && (bank <= BANK_HSRAM_HI)
                         && (off >= OFF_HSRAM_LO) && !off[15])
                begin
                    dec_kind = KIND_RAM;
                    dec_idx  = IDX_W'({bank[3:0], off[12:0]});
                    dec_div  = ROM_SIZE_W'(eff_ram);
                end
            end
        end
    end

    assign dec_need_div = (dec_kind != KIND_NONE) && (dec_div != '0)
                          && ({1'b0, dec_idx} >= dec_div);

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   out_load;
    logic   div_last;
    logic   clr_last;
    logic   m_tvalid_reg;

    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [RAM_AW-1:0]    clr_cnt_reg;

    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign clr_last = (clr_cnt_reg == CLR_LAST);

    // Outputs of the controller
    always_comb
    begin
        out_load = 1'b0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_RESP:
            begin
                out_load = !m_tvalid_reg || m_tready;
                s_tready = out_load;
            end
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = dec_need_div ? ST_DIV : ST_ACCESS;
            end
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (accept)
                    state_next = dec_need_div ? ST_DIV : ST_ACCESS;
                else if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + RAM_AW'(1);
            if (accept)
                div_cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Transaction registers and bit-serial remainder unit
    // ------------------------------------------------------------------
    kind_t                 kind_reg;
    logic                  wr_reg;
    logic                  load_reg;
    logic                  ram_en_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ROM_SIZE_W-1:0] div_reg;
    logic [ROM_SIZE_W-1:0] rem_reg;
    logic [ROM_SIZE_W:0]   rem_sh;
    logic [ROM_SIZE_W+1:0] rem_diff;
    logic [ROM_SIZE_W-1:0] rem_next;

    // Shift one dividend bit in, subtract the divisor when it fits
    assign rem_sh   = {rem_reg, idx_reg[IDX_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, div_reg};
    assign rem_next = rem_diff[ROM_SIZE_W+1] ? rem_sh[ROM_SIZE_W-1:0]
                                             : rem_diff[ROM_SIZE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= dec_kind;
            wr_reg     <= (in_op == OP_WRITE);
            load_reg   <= dec_load;
            ram_en_reg <= (eff_ram != '0);
            wdata_reg  <= in_wdata;
            idx_reg    <= dec_idx;
            div_reg    <= dec_div;
            rem_reg    <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_next;
            if (div_last)
                idx_reg <= rem_next[IDX_W-1:0];
            else
                idx_reg <= {idx_reg[IDX_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Cartridge ROM store
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] rom_mem [ROM_DEPTH];
    logic [DATA_W-1:0] rom_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACCESS)
        begin
            if (load_reg)
                rom_mem[idx_reg[ROM_AW-1:0]] <= wdata_reg;
            else if (kind_reg == KIND_ROM)
                rom_rdata_reg <= rom_mem[idx_reg[ROM_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Save RAM store, swept to zero after reset
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ram_mem [RAM_DEPTH];
    logic [DATA_W-1:0] ram_rdata_reg;
    logic              ram_access;

    assign ram_access = (state_reg == ST_ACCESS) && (kind_reg == KIND_RAM) && ram_en_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            ram_mem[clr_cnt_reg] <= '0;
        else if (ram_access)
        begin
            if (wr_reg)
                ram_mem[idx_reg[RAM_AW-1:0]] <= wdata_reg;
            else
                ram_rdata_reg <= ram_mem[idx_reg[RAM_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] res_data;
    logic [15:0]       m_tdata_reg;

    always_comb
    begin
        res_data = '0;
        case (kind_reg)
            KIND_ROM: res_data = rom_rdata_reg;
            KIND_RAM: res_data = (ram_en_reg && !wr_reg) ? ram_rdata_reg : '0;
            default:  res_data = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {5'b00000, fast_rom_reg, (kind_reg == KIND_RAM),
                            (kind_reg == KIND_ROM), res_data};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("access accepted during RAM clearing pass");

    a_rom_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ACCESS) && (kind_reg == KIND_ROM)) |-> ({1'b0, idx_reg} < eff_rom))
        else $error("ROM index not reduced below ROM size");

    a_ram_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_access |-> ({1'b0, idx_reg} < ROM_SIZE_W'(eff_ram)))
        else $error("RAM index not reduced below RAM size");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg)
        else $error("result register not valid after load");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[8] && m_tdata_reg[9]))
        else $error("ROM and RAM hit flagged together");

endmodule : cartridge_bus_mapper_core

`default_nettype wire

### dv/cartridge_bus_mapper_core_tb.sv
// ----------------------------------------------------------------------------
// cartridge_bus_mapper_core_tb: self-checking bench for the cartridge mapper
// Sends bus reads, bus writes and ROM loads under LoROM and HiROM settings.
// A scoreboard tracks ROM, save RAM and the mapping registers, and each result
// is checked field by field in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module cartridge_bus_mapper_core_tb;
    import cbm_pkg::*;

    localparam int unsigned ROM_WORDS     = 1048576;
    localparam int unsigned RAM_WORDS     = 8192;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned RANDOM_PHASES = 7;

    typedef struct packed {
        logic [7:0] read_data;
        logic       rom_hit;
        logic       ram_hit;
        logic       speed_flag;
    } reply_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;   // operation[1:0], address[25:2], write_data[33:26]
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;   // read_data[7:0], rom_hit[8], ram_hit[9], speed_flag[10]

    // Scoreboard state: mapping registers, memory images, pending results
    logic              map_hirom   = 1'b0;
    logic [22:0]       rom_size_q  = 23'd1048576;
    logic [17:0]       ram_size_q  = 18'd8192;
    logic              fast_rom_q  = 1'b0;
    logic [7:0]        rom_img [int unsigned];
    logic [7:0]        ram_img [RAM_WORDS];
    reply_t            pending_replies [$];

    bit                no_idle     = 1'b0;
    int unsigned       fault_count = 0;
    int unsigned       cycle_count = 0;

    logic [7:0]        edge_banks [0:11] = '{8'h00, 8'h30, 8'h3F, 8'h40, 8'h6F, 8'h70,
                                             8'h7D, 8'h7E, 8'h7F, 8'h80, 8'hBF, 8'hC0};
    logic [15:0]       edge_offs  [0:5]  = '{16'h0000, 16'h5FFF, 16'h6000, 16'h7FFF,
                                             16'h8000, 16'hFFFF};

    cartridge_bus_mapper_core #(
        .ROM_DEPTH (ROM_WORDS),
        .RAM_DEPTH (RAM_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("cartridge_bus_mapper_core: mismatch");
            $finish;
        end
    end

    // Stall the result stream at random
    always @(negedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    // Clamp the configured sizes to the physical depths
    function automatic int unsigned rom_limit();
        return (rom_size_q > ROM_WORDS) ? ROM_WORDS : int'(rom_size_q);
    endfunction

    function automatic int unsigned ram_limit();
        return (ram_size_q > RAM_WORDS) ? RAM_WORDS : int'(ram_size_q);
    endfunction

    // Decode a bus address into ROM, save RAM or nothing
    function automatic void decode_bus(input logic [23:0] addr, output kind_t kind,
                                       output int unsigned idx);
        int unsigned full;
        int unsigned bank;
        int unsigned off;
        int unsigned rom_lim;
        int unsigned ram_lim;
        int unsigned raw;
        full    = addr;
        bank    = addr[23:16];
        off     = addr[15:0];
        rom_lim = rom_limit();
        ram_lim = ram_limit();
        kind    = KIND_NONE;
        idx     = 0;
        if (!map_hirom)
        begin
            if (off >= 'h8000 && bank != BANK_WRAM0 && bank != BANK_WRAM1)
            begin
                raw = (off - 'h8000) + 'h8000 * (bank % 'h80);
                if (raw < rom_lim)
                begin
                    kind = KIND_ROM;
                    idx  = raw;
                end
            end
            else if (bank >= BANK_SRAM_LO && bank <= BANK_SRAM_HI && off < 'h8000)
            begin
                kind = KIND_RAM;
                if (ram_lim != 0)
                    idx = (off + 'h8000 * (bank - BANK_SRAM_LO)) % ram_lim;
            end
        end
        else
        begin
            if (bank >= BANK_HI_ROM || (bank >= BANK_MID_LO && bank <= BANK_SRAM_HI) ||
                ((bank <= 'h3F || (bank >= 'h80 && bank <= 'hBF)) && off >= 'h8000))
            begin
                if (rom_lim != 0)
                begin
                    if (bank >= BANK_HI_ROM)
                        raw = full - 'hC00000;
                    else if (bank >= BANK_MID_LO && bank <= BANK_SRAM_HI)
                        raw = full - 'h400000;
                    else
                        raw = off + 'h10000 * (bank % 'h80);
                    kind = KIND_ROM;
                    idx  = raw % rom_lim;
                end
            end
            else if (bank >= BANK_HSRAM_LO && bank <= BANK_HSRAM_HI &&
                     off >= OFF_HSRAM_LO && off <= 'h7FFF)
            begin
                kind = KIND_RAM;
                if (ram_lim != 0)
                    idx = ((off - OFF_HSRAM_LO) + 'h2000 * (bank - BANK_HSRAM_LO)) % ram_lim;
            end
        end
    endfunction

    // Predict one access and advance the memory images
    function automatic reply_t map_access(input logic [1:0] op, input logic [23:0] addr,
                                          input logic [7:0] data);
        reply_t      r;
        kind_t       kind;
        int unsigned idx;
        r            = '0;
        r.speed_flag = fast_rom_q;
        if (op == OP_READ || op == OP_WRITE)
        begin
            decode_bus(addr, kind, idx);
            if (kind == KIND_ROM && op == OP_READ)
            begin
                r.rom_hit = 1'b1;
                if (rom_img.exists(idx))
                    r.read_data = rom_img[idx];
            end
            else if (kind == KIND_RAM)
            begin
                r.ram_hit = 1'b1;
                if (ram_limit() != 0)
                begin
                    if (op == OP_READ)
                        r.read_data = ram_img[idx];
                    else
                        ram_img[idx] = data;
                end
            end
        end
        else if (op == OP_LOAD)
        begin
            if (addr < ROM_WORDS)
                rom_img[int'(addr)] = data;
        end
        return r;
    endfunction

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin : check_results
        reply_t want;
        reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[10]};
            if (pending_replies.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result: data=%02h rom=%b ram=%b speed=%b",
                             got.read_data, got.rom_hit, got.ram_hit, got.speed_flag);
                fault_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.read_data !== want.read_data || got.rom_hit !== want.rom_hit ||
                    got.ram_hit !== want.ram_hit || got.speed_flag !== want.speed_flag)
                begin
                    if (fault_count < 10)
                        $display("result error: want data=%02h rom=%b ram=%b speed=%b, %s",
                                 want.read_data, want.rom_hit, want.ram_hit, want.speed_flag,
                                 $sformatf("got data=%02h rom=%b ram=%b speed=%b",
                                           got.read_data, got.rom_hit, got.ram_hit,
                                           got.speed_flag));
                    fault_count++;
                end
            end
        end
    end

    // Send one access transaction, idling at random first
    task automatic send_item(input logic [1:0] op, input logic [23:0] addr,
                             input logic [7:0] data);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, addr, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_replies.push_back(map_access(op, addr, data));
    endtask

    // Load the ROM byte a read would hit if it was never loaded, then send
    task automatic issue(input logic [1:0] op, input logic [23:0] addr, input logic [7:0] data);
        kind_t       kind;
        int unsigned idx;
        if (op == OP_READ)
        begin
            decode_bus(addr, kind, idx);
            if (kind == KIND_ROM && !rom_img.exists(idx))
                send_item(OP_LOAD, 24'(idx), 8'($urandom));
        end
        send_item(op, addr, data);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one mapping register; the caller lowers the write enable
    task automatic write_reg(input logic [1:0] index, input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        case (index)
            CFG_MAP_MODE: map_hirom  = value[0];
            CFG_ROM_SIZE: rom_size_q = value[22:0];
            CFG_RAM_SIZE: ram_size_q = value[17:0];
            CFG_FAST_ROM: fast_rom_q = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic hirom, input int unsigned rom_sz,
                                 input int unsigned ram_sz, input logic fast);
        drain_replies();
        write_reg(CFG_MAP_MODE, hirom);
        write_reg(CFG_ROM_SIZE, rom_sz);
        write_reg(CFG_RAM_SIZE, ram_sz);
        write_reg(CFG_FAST_ROM, fast);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // LoROM after reset: ROM bounds, mirrors, save RAM wrap, ROM writes, misses
    task automatic test_default_lorom();
        issue(OP_LOAD,   24'h000000, 8'hA5);
        issue(OP_LOAD,   24'h0FFFFF, 8'h5A);
        issue(OP_LOAD,   24'hFFFFFF, 8'hFF);
        issue(OP_READ,   24'h808000, 8'h00);
        issue(OP_READ,   24'h1FFFFF, 8'h00);
        issue(OP_READ,   24'h208000, 8'h00);
        issue(OP_READ,   24'h7E8000, 8'h00);
        issue(OP_WRITE,  24'h7D7FFF, 8'hC3);
        issue(OP_READ,   24'h701FFF, 8'h00);
        issue(OP_WRITE,  24'h008000, 8'h77);
        issue(OP_READ,   24'h000000, 8'h00);
        issue(OP_UNUSED, 24'hFFFFFF, 8'hFF);
    endtask

    // HiROM with oversized sizes clamped to the depths
    task automatic test_hirom_extremes();
        apply_setting(1'b1, 4194304, 131072, 1'b1);
        issue(OP_READ,  24'hFFFFFF, 8'h00);
        issue(OP_READ,  24'h400000, 8'h00);
        issue(OP_READ,  24'hBFFFFF, 8'h00);
        issue(OP_WRITE, 24'h306000, 8'h11);
        issue(OP_READ,  24'h3F7FFF, 8'h00);
        issue(OP_READ,  24'h7E8000, 8'h00);
    endtask

    // One-byte ROM, no save RAM, then the widest register values
    task automatic test_tiny_sizes();
        apply_setting(1'b1, 1, 0, 1'b0);
        issue(OP_READ,  24'hC12345, 8'h00);
        issue(OP_WRITE, 24'h306000, 8'hEE);
        issue(OP_READ,  24'h306000, 8'h00);
        apply_setting(1'b0, 23'h7FFFFF, 18'h3FFFF, 1'b1);
        issue(OP_READ,  24'h808000, 8'h00);
    endtask

    // Zero ROM size turns every ROM access into a miss
    task automatic test_zero_rom();
        apply_setting(1'b0, 0, 8192, 1'b1);
        issue(OP_READ, 24'h008000, 8'h00);
        apply_setting(1'b1, 0, 0, 1'b0);
        issue(OP_READ, 24'hC00000, 8'h00);
    endtask

    // Random settings, each with a stream of accesses, many aimed at mapped windows
    task automatic test_random_mappings();
        logic [1:0]  op;
        logic [23:0] addr;
        logic [7:0]  bank;
        logic [15:0] off;
        kind_t       kind;
        int unsigned idx;
        int unsigned sel;
        int unsigned rom_sz;
        int unsigned ram_sz;
        logic [23:0] recent [$];
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 3))
                0: rom_sz = $urandom_range(0, 23'h7FFFFF);
                1: rom_sz = $urandom_range(1, 'h3FFFFF);
                2: rom_sz = 1 << $urandom_range(15, 22);
                default: rom_sz = $urandom_range(1, 'h20000);
            endcase
            case ($urandom_range(0, 4))
                0: ram_sz = 0;
                1: ram_sz = $urandom_range(0, 18'h3FFFF);
                2: ram_sz = 1 << $urandom_range(11, 17);
                default: ram_sz = $urandom_range(1, RAM_WORDS);
            endcase
            apply_setting(1'(p % 2), rom_sz, ram_sz, 1'($urandom_range(0, 1)));
            no_idle = (p == 2);
            recent.delete();
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                sel = $urandom_range(0, 99);
                op  = (sel < 45) ? OP_READ : (sel < 75) ? OP_WRITE :
                      (sel < 95) ? OP_LOAD : OP_UNUSED;

                // Pick an address: reuse, uniform, save RAM, ROM or a boundary
                sel = $urandom_range(0, 99);
                if (sel < 15 && recent.size() != 0)
                    addr = recent[$urandom_range(0, recent.size() - 1)];
                else if (sel < 40)
                    addr = 24'($urandom);
                else if (sel < 65)
                begin
                    if (!map_hirom)
                        addr = {8'($urandom_range('h70, 'h7D)), 16'($urandom_range(0, 'h7FFF))};
                    else
                        addr = {8'($urandom_range('h30, 'h3F)),
                                16'($urandom_range('h6000, 'h7FFF))};
                end
                else if (sel < 85)
                begin
                    off = 16'h8000 | 16'($urandom);
                    if (!map_hirom)
                        bank = {1'($urandom), 7'($urandom_range(0, 'h1F))};
                    else
                        case ($urandom_range(0, 2))
                            0: bank = 8'($urandom_range('hC0, 'hFF));
                            1: bank = 8'($urandom_range('h40, 'h7D));
                            default: bank = {1'($urandom), 7'($urandom_range(0, 'h3F))};
                        endcase
                    addr = {bank, off};
                end
                else
                    addr = {edge_banks[$urandom_range(0, 11)], edge_offs[$urandom_range(0, 5)]};

                // Aim most loads at bytes that reads will hit
                if (op == OP_LOAD)
                begin
                    decode_bus(addr, kind, idx);
                    if (kind == KIND_ROM && $urandom_range(0, 3) != 0)
                        addr = 24'(idx);
                end
                else if (op != OP_UNUSED)
                begin
                    recent.push_back(addr);
                    if (recent.size() > 32)
                        void'(recent.pop_front());
                end

                issue(op, addr, 8'($urandom));

                // Hold the sender now and then until the pipe empties
                if ($urandom_range(0, 49) == 0)
                    drain_replies();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_MAP_MODE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        foreach (ram_img[i])
            ram_img[i] = 8'h00;

        // Reset, then hold until the save RAM clearing pass is done
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        test_default_lorom();
        drain_replies();
        test_hirom_extremes();
        test_tiny_sizes();
        test_zero_rom();
        test_random_mappings();

        drain_replies();
        repeat (30) @(posedge clk);
        if (fault_count == 0 && pending_replies.size() == 0)
            $display("cartridge_bus_mapper_core: match");
        else
            $display("cartridge_bus_mapper_core: mismatch");
        $finish;
    end

endmodule
